// ===== sv/tscc_pkg.sv =====
// Shared types, codes and constants for the TCP sender window controller.
package tscc_pkg;

   localparam int unsigned SEGMENT_BYTES_DEF = 1024;

   localparam logic [15:0] WINDOW_MAX   = 16'hFFFF;
   localparam logic [16:0] TALLY_MAX    = 17'h1FFFF;
   localparam logic [1:0]  DUP_LIMIT    = 2'd3;
   localparam logic [15:0] THRESH_FLOOR = 16'd2;

   // event kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_TIMEOUT = 2'd1;
   localparam logic [1:0] KIND_SEND    = 2'd2;

   // ack flags
   localparam logic [1:0] FLAG_ACK = 2'd0;
   localparam logic [1:0] FLAG_FIN = 2'd1;

   // commands
   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_SEND = 3'd1;
   localparam logic [2:0] ACT_FIN  = 3'd2;
   localparam logic [2:0] ACT_RETX = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ack_number;
      logic [1:0]  ack_flag;
      logic [10:0] segment_length;
   } item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] sequence_res;
      logic        arm_timer;
      logic        disarm_timer;
      logic [15:0] window_now;
      logic [15:0] threshold_now;
      logic        threshold_unset;
      logic        in_slow_start;
      logic [15:0] flight_now;
   } res_type;

   // core -> credit unit
   typedef struct packed {
      logic        start;
      logic        take;
      logic [31:0] dividend;
   } crd_req_type;

   // credit unit -> core
   typedef struct packed {
      logic        valid;
      logic [16:0] credit;
   } crd_rsp_type;

endpackage

// ===== sv/tscc_credit.sv =====
// Segment credit unit: ceil(acked bytes / segment size) by reciprocal multiply.
module tscc_credit #(
   parameter int unsigned SEGMENT_BYTES = tscc_pkg::SEGMENT_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tscc_pkg::crd_req_type  crd_req,
   output tscc_pkg::crd_rsp_type  crd_rsp
);

   localparam int unsigned SHIFT = $clog2(SEGMENT_BYTES);
   // ceil(2^(32+SHIFT) / S) fits 33 bits and is exact for any 32-bit dividend
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << (32 + SHIFT)) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES);
   localparam logic [32:0] RECIP = RECIP_WIDE[32:0];

   logic        mul_vld_ff, mul_vld_in;
   logic [48:0] prod_hi_ff, prod_hi_in;
   logic [48:0] prod_lo_ff, prod_lo_in;
   logic        crd_vld_ff, crd_vld_in;
   logic [16:0] credit_ff, credit_in;
   logic [80:0] prod_sum;
   logic [31:0] quot;

   // dividend is (acked bytes - 1); ceiling = floor + 1
   assign prod_hi_in = {33'd0, crd_req.dividend[31:16]} * {16'd0, RECIP};
   assign prod_lo_in = {33'd0, crd_req.dividend[15:0]} * {16'd0, RECIP};
   assign mul_vld_in = crd_req.start;

   assign prod_sum = {16'd0, prod_hi_ff, 16'd0} + {32'd0, prod_lo_ff};
   assign quot     = prod_sum[32 + SHIFT +: 32];

   always_comb begin
      if (quot >= {15'd0, tscc_pkg::TALLY_MAX}) begin
         credit_in = tscc_pkg::TALLY_MAX;
      end else begin
         credit_in = quot[16:0] + 17'd1;
      end
   end

   always_comb begin
      if (mul_vld_ff) begin
         crd_vld_in = 1'b1;
      end else if (crd_req.take) begin
         crd_vld_in = 1'b0;
      end else begin
         crd_vld_in = crd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         crd_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= mul_vld_in;
         crd_vld_ff <= crd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (crd_req.start) begin
         prod_hi_ff <= prod_hi_in;
         prod_lo_ff <= prod_lo_in;
      end
      if (mul_vld_ff) begin
         credit_ff <= credit_in;
      end
   end

   assign crd_rsp.valid  = crd_vld_ff;
   assign crd_rsp.credit = credit_ff;

endmodule

// ===== sv/tscc_core.sv =====
// Window state and per-event decision logic.
module tscc_core #(
   parameter int unsigned SEGMENT_BYTES = tscc_pkg::SEGMENT_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_vld,
   input  tscc_pkg::item_type     item,
   input  logic                   out_ok,
   output logic                   fire,
   output tscc_pkg::res_type      res,
   output tscc_pkg::crd_req_type  crd_req,
   input  tscc_pkg::crd_rsp_type  crd_rsp
);

   localparam logic [15:0] SEG16 = 16'(SEGMENT_BYTES);
   localparam logic [31:0] SEG32 = 32'(SEGMENT_BYTES);

   typedef enum logic {
      ST_RUN,
      ST_WAIT
   } st_type;

   st_type      st_ff, st_in;
   logic [15:0] window_ff, window_in;
   logic [31:0] win_bytes_ff, win_bytes_in;   // SEGMENT_BYTES * window
   logic [15:0] flight_ff, flight_in;
   logic [31:0] next_off_ff, next_off_in;
   logic [31:0] base_off_ff, base_off_in;
   logic [15:0] thresh_ff, thresh_in;
   logic        thresh_inf_ff, thresh_inf_in;
   logic        slow_ff, slow_in;
   logic [16:0] tally_ff, tally_in;
   logic [1:0]  dup_ff, dup_in;
   logic        timer_ff, timer_in;
   logic [31:0] timed_off_ff, timed_off_in;
   logic        done_ff, done_in;

   logic        new_ack;
   logic [15:0] loss_thresh;
   logic [17:0] tally_sum;
   logic [16:0] tally_sat;
   logic [15:0] flight_dec;
   logic [15:0] flight_inc;
   logic [15:0] win_inc;
   logic [31:0] bytes_inc;
   logic [32:0] wend;
   logic        room;
   logic [15:0] len_wide;
   logic [15:0] len_clip;
   logic [1:0]  dup_next;
   logic [16:0] credit;

   tscc_pkg::res_type res_c;

   assign credit  = crd_rsp.credit;
   assign new_ack = !done_ff && (item.kind == tscc_pkg::KIND_ACK)
                    && (item.ack_flag == tscc_pkg::FLAG_ACK)
                    && (item.ack_number > base_off_ff);

   assign loss_thresh = ({1'b0, window_ff[15:1]} > tscc_pkg::THRESH_FLOOR) ?
                        {1'b0, window_ff[15:1]} : tscc_pkg::THRESH_FLOOR;

   assign tally_sum  = {1'b0, tally_ff} + {1'b0, credit};
   assign tally_sat  = (tally_sum > {1'b0, tscc_pkg::TALLY_MAX}) ?
                       tscc_pkg::TALLY_MAX : tally_sum[16:0];
   assign flight_dec = (credit >= {1'b0, flight_ff}) ? 16'd0 : flight_ff - credit[15:0];
   assign flight_inc = (flight_ff != tscc_pkg::WINDOW_MAX) ? flight_ff + 16'd1 : flight_ff;
   assign win_inc    = (window_ff != tscc_pkg::WINDOW_MAX) ? window_ff + 16'd1 : window_ff;
   assign bytes_inc  = (window_ff != tscc_pkg::WINDOW_MAX) ? win_bytes_ff + SEG32
                                                            : win_bytes_ff;

   assign wend     = {1'b0, base_off_ff} + {1'b0, win_bytes_ff};
   assign room     = (window_ff > flight_ff) && ({1'b0, next_off_ff} <= wend);
   assign len_wide = {5'd0, item.segment_length};
   assign len_clip = (len_wide > SEG16) ? SEG16 : len_wide;
   assign dup_next = dup_ff + 2'd1;

   // state after the event held in the input register
   always_comb begin
      window_in     = window_ff;
      win_bytes_in  = win_bytes_ff;
      flight_in     = flight_ff;
      next_off_in   = next_off_ff;
      base_off_in   = base_off_ff;
      thresh_in     = thresh_ff;
      thresh_inf_in = thresh_inf_ff;
      slow_in       = slow_ff;
      tally_in      = tally_ff;
      dup_in        = dup_ff;
      timer_in      = timer_ff;
      timed_off_in  = timed_off_ff;
      done_in       = done_ff;
      res_c.action       = tscc_pkg::ACT_NONE;
      res_c.sequence_res = 32'd0;
      res_c.arm_timer    = 1'b0;
      res_c.disarm_timer = 1'b0;
      if (!done_ff) begin
         case (item.kind)
            tscc_pkg::KIND_ACK: begin
               if (item.ack_flag == tscc_pkg::FLAG_FIN) begin
                  res_c.action = tscc_pkg::ACT_DONE;
                  done_in      = 1'b1;
               end else if (item.ack_flag == tscc_pkg::FLAG_ACK) begin
                  if (new_ack) begin
                     dup_in    = 2'd0;
                     flight_in = flight_dec;
                     if (slow_ff) begin
                        tally_in     = tally_sat;
                        window_in    = win_inc;
                        win_bytes_in = bytes_inc;
                        if (!thresh_inf_ff && (win_inc >= thresh_ff)) begin
                           slow_in = 1'b0;
                        end
                     end else if (tally_sat >= {1'b0, window_ff}) begin
                        tally_in     = 17'd0;
                        window_in    = win_inc;
                        win_bytes_in = bytes_inc;
                     end else begin
                        tally_in = tally_sat;
                     end
                     base_off_in = item.ack_number;
                     if (timer_ff && (timed_off_ff <= item.ack_number)) begin
                        timer_in           = 1'b0;
                        res_c.disarm_timer = 1'b1;
                     end
                  end else if (item.ack_number == base_off_ff) begin
                     if (dup_next == tscc_pkg::DUP_LIMIT) begin
                        dup_in             = 2'd0;
                        thresh_in          = loss_thresh;
                        thresh_inf_in      = 1'b0;
                        slow_in            = 1'b1;
                        window_in          = 16'd1;
                        win_bytes_in       = SEG32;
                        res_c.action       = tscc_pkg::ACT_RETX;
                        res_c.sequence_res = base_off_ff;
                     end else begin
                        dup_in = dup_next;
                     end
                  end
               end
            end
            tscc_pkg::KIND_TIMEOUT: begin
               thresh_in          = loss_thresh;
               thresh_inf_in      = 1'b0;
               slow_in            = 1'b1;
               window_in          = 16'd1;
               win_bytes_in       = SEG32;
               res_c.action       = tscc_pkg::ACT_RETX;
               res_c.sequence_res = base_off_ff;
            end
            tscc_pkg::KIND_SEND: begin
               if (room || !timer_ff) begin
                  res_c.sequence_res = next_off_ff;
                  if (len_clip == 16'd0) begin
                     res_c.action = tscc_pkg::ACT_FIN;
                  end else begin
                     res_c.action = tscc_pkg::ACT_SEND;
                     if (!timer_ff) begin
                        timer_in        = 1'b1;
                        res_c.arm_timer = 1'b1;
                        timed_off_in    = next_off_ff;
                     end
                     next_off_in = next_off_ff + {16'd0, len_clip};
                  end
                  flight_in = flight_inc;
               end
            end
            default: ;
         endcase
      end
      res_c.window_now      = window_in;
      res_c.threshold_now   = thresh_inf_in ? 16'd0 : thresh_in;
      res_c.threshold_unset = thresh_inf_in;
      res_c.in_slow_start   = slow_in;
      res_c.flight_now      = flight_in;
   end

   // sequencing: a new ACK waits for its credit, everything else only for out_ok
   always_comb begin
      st_in            = st_ff;
      fire             = 1'b0;
      crd_req.start    = 1'b0;
      crd_req.take     = 1'b0;
      crd_req.dividend = item.ack_number - base_off_ff - 32'd1;
      case (st_ff)
         ST_RUN: begin
            if (item_vld) begin
               if (new_ack) begin
                  crd_req.start = 1'b1;
                  st_in         = ST_WAIT;
               end else if (out_ok) begin
                  fire = 1'b1;
               end
            end
         end
         ST_WAIT: begin
            if (crd_rsp.valid && out_ok) begin
               fire         = 1'b1;
               crd_req.take = 1'b1;
               st_in        = ST_RUN;
            end
         end
         default: st_in = ST_RUN;
      endcase
   end

   assign res = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_RUN;
         window_ff     <= 16'd1;
         win_bytes_ff  <= SEG32;
         flight_ff     <= 16'd0;
         next_off_ff   <= 32'd0;
         base_off_ff   <= 32'd0;
         thresh_ff     <= 16'd0;
         thresh_inf_ff <= 1'b1;
         slow_ff       <= 1'b1;
         tally_ff      <= 17'd0;
         dup_ff        <= 2'd0;
         timer_ff      <= 1'b0;
         timed_off_ff  <= 32'd0;
         done_ff       <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (fire) begin
            window_ff     <= window_in;
            win_bytes_ff  <= win_bytes_in;
            flight_ff     <= flight_in;
            next_off_ff   <= next_off_in;
            base_off_ff   <= base_off_in;
            thresh_ff     <= thresh_in;
            thresh_inf_ff <= thresh_inf_in;
            slow_ff       <= slow_in;
            tally_ff      <= tally_in;
            dup_ff        <= dup_in;
            timer_ff      <= timer_in;
            timed_off_ff  <= timed_off_in;
            done_ff       <= done_in;
         end
      end
   end

   a_window_nonzero: assert property (@(posedge clock) disable iff (reset)
      window_ff != 16'd0)
      else $error("congestion window reached zero");

   a_wait_holds_item: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_WAIT) |-> item_vld)
      else $error("input beat dropped while credit pending");

   a_credit_only_waiting: assert property (@(posedge clock) disable iff (reset)
      crd_rsp.valid |-> (st_ff == ST_WAIT))
      else $error("credit ready with no ACK waiting");

   a_start_sets_timer: assert property (@(posedge clock) disable iff (reset)
      (fire && res_c.arm_timer) |=> timer_ff)
      else $error("timer start not recorded");

   a_thresh_floor: assert property (@(posedge clock) disable iff (reset)
      !thresh_inf_ff |-> (thresh_ff >= tscc_pkg::THRESH_FLOOR))
      else $error("finite threshold below floor");

endmodule

// ===== sv/tcp_sender_congestion_control.sv =====
// Path: input register, then result register; a new (advancing) ACK also passes through
// the product and credit registers of the reciprocal-multiply credit unit.
// Throughput: one event per cycle while results are taken; a new ACK waits for its credit.
// Input and result registers decouple the channels, so a beat is taken while a result waits.
// Reset (synchronous, active high) restores window 1, infinite threshold, zero offsets
// and counts; no clearing pass.
module tcp_sender_congestion_control #(
   parameter int unsigned SEGMENT_BYTES = tscc_pkg::SEGMENT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_ack_number,
   input  logic [1:0]  req_ack_flag,
   input  logic [10:0] req_segment_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_sequence_res,
   output logic        rsp_start_timer,
   output logic        rsp_stop_timer,
   output logic [15:0] rsp_window_now,
   output logic [15:0] rsp_threshold_now,
   output logic        rsp_threshold_unset,
   output logic        rsp_in_slow_start,
   output logic [15:0] rsp_flight_now
);

   logic                  in_vld_ff, in_vld_in;
   tscc_pkg::item_type    item_ff, item_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   tscc_pkg::res_type     rsp_ff;
   tscc_pkg::res_type     res;
   tscc_pkg::crd_req_type crd_req;
   tscc_pkg::crd_rsp_type crd_rsp;
   logic                  out_ok;
   logic                  fire;
   logic                  req_take;

   assign out_ok    = !rsp_vld_ff || rsp_ready;
   assign req_ready = !in_vld_ff || fire;
   assign req_take  = req_valid && req_ready;

   assign item_in.kind           = req_kind;
   assign item_in.ack_number     = req_ack_number;
   assign item_in.ack_flag       = req_ack_flag;
   assign item_in.segment_length = req_segment_length;

   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
      if (fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   tscc_core #(
      .SEGMENT_BYTES(SEGMENT_BYTES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .item_vld(in_vld_ff),
      .item    (item_ff),
      .out_ok  (out_ok),
      .fire    (fire),
      .res     (res),
      .crd_req (crd_req),
      .crd_rsp (crd_rsp)
   );

   tscc_credit #(
      .SEGMENT_BYTES(SEGMENT_BYTES)
   ) u_credit (
      .clock  (clock),
      .reset  (reset),
      .crd_req(crd_req),
      .crd_rsp(crd_rsp)
   );

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_action          = rsp_ff.action;
   assign rsp_sequence_res    = rsp_ff.sequence_res;
   assign rsp_start_timer     = rsp_ff.arm_timer;
   assign rsp_stop_timer      = rsp_ff.disarm_timer;
   assign rsp_window_now      = rsp_ff.window_now;
   assign rsp_threshold_now   = rsp_ff.threshold_now;
   assign rsp_threshold_unset = rsp_ff.threshold_unset;
   assign rsp_in_slow_start   = rsp_ff.in_slow_start;
   assign rsp_flight_now      = rsp_ff.flight_now;

endmodule

// ===== tb/tscc_tb_pkg.sv =====
// Scoreboard for the TCP sender window controller: event predictor and expected command queue.
package tscc_tb_pkg;

   // codes the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [1:0] FLAG_OTHER  = 2'd2;
   localparam logic [1:0] FLAG_SPARE  = 2'd3;

   class cwnd_scoreboard;
      logic [15:0] cwnd;
      logic [15:0] flight;
      logic [15:0] ssthresh;
      logic        ssthresh_inf;
      logic        ss_mode;
      logic [31:0] snd_next;
      logic [31:0] snd_base;
      logic [16:0] ack_credit_sum;
      logic [1:0]  dup_acks;
      logic        timer_run;
      logic [31:0] timed_seq;
      logic        done;
      tscc_pkg::res_type expected_cmds[$];
      int          errors;

      function new();
         cwnd           = 16'd1;
         flight         = 16'd0;
         ssthresh       = 16'd0;
         ssthresh_inf   = 1'b1;
         ss_mode        = 1'b1;
         snd_next       = 32'd0;
         snd_base       = 32'd0;
         ack_credit_sum = 17'd0;
         dup_acks       = 2'd0;
         timer_run      = 1'b0;
         timed_seq      = 32'd0;
         done           = 1'b0;
         errors         = 0;
      endfunction

      // third duplicate or timeout: threshold to half the window (floor 2), window 1, restart slow start
      function void enter_loss();
         logic [15:0] half;
         half         = cwnd >> 1;
         ssthresh     = (half > tscc_pkg::THRESH_FLOOR) ? half : tscc_pkg::THRESH_FLOOR;
         ssthresh_inf = 1'b0;
         ss_mode      = 1'b1;
         cwnd         = 16'd1;
      endfunction

      function void note_event(input logic [1:0] kind, input logic [31:0] ack_no,
                               input logic [1:0] flag, input logic [10:0] seg_len);
         tscc_pkg::res_type cmd;
         logic [31:0]     gap_bytes;
         longint unsigned credit;
         longint unsigned sum;
         longint unsigned wnd_end;
         logic [10:0]     len;
         cmd = '0;
         if (!done) begin
            case (kind)
               tscc_pkg::KIND_ACK: begin
                  if (flag == tscc_pkg::FLAG_FIN) begin
                     cmd.action = tscc_pkg::ACT_DONE;
                     done = 1'b1;
                  end else if (flag == tscc_pkg::FLAG_ACK) begin
                     if (ack_no > snd_base) begin
                        gap_bytes = ack_no - snd_base;
                        credit = 64'(gap_bytes / tscc_pkg::SEGMENT_BYTES_DEF);
                        if (gap_bytes % tscc_pkg::SEGMENT_BYTES_DEF != 0) credit++;
                        dup_acks = 2'd0;
                        sum = 64'(ack_credit_sum) + credit;
                        ack_credit_sum = (sum > 64'(tscc_pkg::TALLY_MAX)) ?
                                         tscc_pkg::TALLY_MAX : 17'(sum);
                        flight = (credit >= 64'(flight)) ? 16'd0 : flight - 16'(credit);
                        if (ss_mode) begin
                           if (cwnd < tscc_pkg::WINDOW_MAX) cwnd++;
                           if (!ssthresh_inf && cwnd >= ssthresh) ss_mode = 1'b0;
                        end else if (ack_credit_sum >= 17'(cwnd)) begin
                           ack_credit_sum = 17'd0;
                           if (cwnd < tscc_pkg::WINDOW_MAX) cwnd++;
                        end
                        snd_base = ack_no;
                        if (timer_run && timed_seq <= snd_base) begin
                           timer_run = 1'b0;
                           cmd.disarm_timer = 1'b1;
                        end
                     end else if (ack_no == snd_base) begin
                        dup_acks = dup_acks + 2'd1;
                        if (dup_acks >= tscc_pkg::DUP_LIMIT) begin
                           dup_acks = 2'd0;
                           enter_loss();
                           cmd.action = tscc_pkg::ACT_RETX;
                           cmd.sequence_res = snd_base;
                        end
                     end
                  end
               end
               tscc_pkg::KIND_TIMEOUT: begin
                  enter_loss();
                  cmd.action = tscc_pkg::ACT_RETX;
                  cmd.sequence_res = snd_base;
               end
               tscc_pkg::KIND_SEND: begin
                  wnd_end = 64'(snd_base) + 64'(tscc_pkg::SEGMENT_BYTES_DEF) * 64'(cwnd);
                  if (((cwnd > flight) && (64'(snd_next) <= wnd_end)) || !timer_run) begin
                     len = (seg_len > tscc_pkg::SEGMENT_BYTES_DEF) ?
                           11'(tscc_pkg::SEGMENT_BYTES_DEF) : seg_len;
                     cmd.sequence_res = snd_next;
                     if (len == 11'd0) begin
                        cmd.action = tscc_pkg::ACT_FIN;
                     end else begin
                        cmd.action = tscc_pkg::ACT_SEND;
                        if (!timer_run) begin
                           timer_run = 1'b1;
                           cmd.arm_timer = 1'b1;
                           timed_seq = snd_next;
                        end
                        snd_next = snd_next + 32'(len);
                     end
                     if (flight < tscc_pkg::WINDOW_MAX) flight++;
                  end
               end
               default: ;
            endcase
         end
         cmd.window_now      = cwnd;
         cmd.threshold_now   = ssthresh_inf ? 16'd0 : ssthresh;
         cmd.threshold_unset = ssthresh_inf;
         cmd.in_slow_start   = ss_mode;
         cmd.flight_now      = flight;
         expected_cmds.push_back(cmd);
      endfunction

      function void compare_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_command(input tscc_pkg::res_type got);
         tscc_pkg::res_type want;
         if (expected_cmds.size() == 0) begin
            $error("command beat with no event waiting: action %0d", got.action);
            errors++;
            return;
         end
         want = expected_cmds.pop_front();
         compare_field("action", 32'(want.action), 32'(got.action));
         compare_field("sequence_res", want.sequence_res, got.sequence_res);
         compare_field("rsp_start_timer", 32'(want.arm_timer), 32'(got.arm_timer));
         compare_field("rsp_stop_timer", 32'(want.disarm_timer), 32'(got.disarm_timer));
         compare_field("window_now", 32'(want.window_now), 32'(got.window_now));
         compare_field("threshold_now", 32'(want.threshold_now), 32'(got.threshold_now));
         compare_field("threshold_unset", 32'(want.threshold_unset),
                       32'(got.threshold_unset));
         compare_field("in_slow_start", 32'(want.in_slow_start), 32'(got.in_slow_start));
         compare_field("flight_now", 32'(want.flight_now), 32'(got.flight_now));
      endfunction
   endclass

endpackage

// ===== tb/tb_tcp_sender_congestion_control.sv =====
// Self-checking testbench for the TCP sender window controller.
module tb_tcp_sender_congestion_control;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = '0;
   logic [31:0] req_ack_number = '0;
   logic [1:0]  req_ack_flag = '0;
   logic [10:0] req_segment_length = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [31:0] rsp_sequence_res;
   logic        rsp_start_timer;
   logic        rsp_stop_timer;
   logic [15:0] rsp_window_now;
   logic [15:0] rsp_threshold_now;
   logic        rsp_threshold_unset;
   logic        rsp_in_slow_start;
   logic [15:0] rsp_flight_now;

   tscc_tb_pkg::cwnd_scoreboard sb;
   bit tx_steady = 1'b0;
   bit rsp_hold_req = 1'b0;
   bit rsp_hold_seen = 1'b0;
   int rsp_hold_left = 0;
   int unsigned rx_cycle = 0;

   tcp_sender_congestion_control dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_ack_number      (req_ack_number),
      .req_ack_flag        (req_ack_flag),
      .req_segment_length  (req_segment_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_action          (rsp_action),
      .rsp_sequence_res    (rsp_sequence_res),
      .rsp_start_timer     (rsp_start_timer),
      .rsp_stop_timer      (rsp_stop_timer),
      .rsp_window_now      (rsp_window_now),
      .rsp_threshold_now   (rsp_threshold_now),
      .rsp_threshold_unset (rsp_threshold_unset),
      .rsp_in_slow_start   (rsp_in_slow_start),
      .rsp_flight_now      (rsp_flight_now)
   );

   always #2 clock = ~clock;

   // offer one event beat, wait for acceptance, then book it in the scoreboard
   task automatic put_event(input logic [1:0] kind, input logic [31:0] ack_no,
                            input logic [1:0] flag, input logic [10:0] seg_len);
      if (!tx_steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= kind;
      req_ack_number     <= ack_no;
      req_ack_flag       <= flag;
      req_segment_length <= seg_len;
      do @(posedge clock); while (!req_ready);
      sb.note_event(kind, ack_no, flag, seg_len);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_cmds.size() != 0);
   endtask

   // build up in-flight count and window, then move the base up to next
   task automatic ramp_to_limits();
      repeat (20) put_event(tscc_pkg::KIND_SEND, $urandom, 2'($urandom_range(3)), 11'd0);
      repeat (20) put_event(tscc_pkg::KIND_ACK, sb.snd_base + 32'd1, tscc_pkg::FLAG_ACK,
                            11'($urandom));
      repeat (8) put_event(tscc_pkg::KIND_SEND, $urandom, 2'($urandom_range(3)), 11'd1024);
      put_event(tscc_pkg::KIND_ACK, sb.snd_next, tscc_pkg::FLAG_ACK, 11'd0);
   endtask

   task automatic directed_cases();
      put_event(tscc_pkg::KIND_TIMEOUT, 32'd0, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd1024);
      put_event(tscc_pkg::KIND_SEND, '1, tscc_pkg::FLAG_FIN, 11'd2047);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd1);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd0);
      // partial segment rounds the credit up
      put_event(tscc_pkg::KIND_ACK, sb.snd_base + 32'd1, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_ACK, sb.snd_next, tscc_pkg::FLAG_ACK, 11'd0);
      repeat (3) put_event(tscc_pkg::KIND_ACK, sb.snd_base, tscc_pkg::FLAG_ACK, '1);
      put_event(tscc_pkg::KIND_ACK, 32'd0, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_ACK, '1, tscc_tb_pkg::FLAG_OTHER, '1);
      put_event(tscc_pkg::KIND_ACK, '1, tscc_tb_pkg::FLAG_SPARE, 11'd0);
      put_event(tscc_tb_pkg::KIND_UNUSED, '1, tscc_tb_pkg::FLAG_SPARE, '1);
      put_event(tscc_pkg::KIND_TIMEOUT, '1, tscc_tb_pkg::FLAG_SPARE, '1);
      // window already 1: threshold floors at 2
      put_event(tscc_pkg::KIND_TIMEOUT, 32'd0, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd700);
   endtask

   task automatic random_traffic(input int count);
      int          pick;
      logic [10:0] len;
      for (int i = 0; i < count; i++) begin
         tx_steady = (i >= 400 && i < 700);
         if (i == 200) rsp_hold_req = 1'b1;
         if (i == 850) drain_wait();
         pick = $urandom_range(99);
         if (pick < 38 || (pick < 72 && sb.snd_next <= sb.snd_base)) begin
            pick = $urandom_range(99);
            if (pick < 5) len = 11'd0;
            else if (pick < 15) len = 11'($urandom_range(2047, 1025));
            else len = 11'($urandom_range(1024, 1));
            put_event(tscc_pkg::KIND_SEND, $urandom, 2'($urandom_range(3)), len);
         end else if (pick < 72) begin
            put_event(tscc_pkg::KIND_ACK,
                      sb.snd_base + $urandom_range(sb.snd_next - sb.snd_base, 1),
                      tscc_pkg::FLAG_ACK, 11'($urandom));
         end else if (pick < 82) begin
            repeat ($urandom_range(3, 1))
               put_event(tscc_pkg::KIND_ACK, sb.snd_base, tscc_pkg::FLAG_ACK, 11'($urandom));
         end else if (pick < 87) begin
            put_event(tscc_pkg::KIND_TIMEOUT, $urandom, 2'($urandom_range(3)),
                      11'($urandom));
         end else begin
            case ($urandom_range(2))
               0: put_event(tscc_pkg::KIND_ACK, (sb.snd_base == 0) ? 32'd0 :
                            $urandom_range(sb.snd_base - 32'd1, 0), tscc_pkg::FLAG_ACK,
                            11'($urandom));
               1: put_event(tscc_pkg::KIND_ACK, $urandom, 2'($urandom_range(3, 2)),
                            11'($urandom));
               default: put_event(tscc_tb_pkg::KIND_UNUSED, $urandom, 2'($urandom_range(3)),
                                  11'($urandom));
            endcase
         end
      end
      tx_steady = 1'b0;
   endtask

   // huge ACK saturates the credit tally, then the FIN ACK ends the transfer
   task automatic finish_transfer();
      put_event(tscc_pkg::KIND_ACK, '1, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd512);
      put_event(tscc_pkg::KIND_ACK, 32'd0, tscc_pkg::FLAG_FIN, 11'd0);
      put_event(tscc_pkg::KIND_SEND, 32'd0, tscc_pkg::FLAG_ACK, 11'd100);
      put_event(tscc_pkg::KIND_TIMEOUT, 32'd0, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_ACK, '1, tscc_pkg::FLAG_ACK, 11'd0);
      put_event(tscc_pkg::KIND_ACK, 32'd5, tscc_pkg::FLAG_FIN, 11'd0);
      put_event(tscc_tb_pkg::KIND_UNUSED, '1, tscc_tb_pkg::FLAG_SPARE, '1);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check_command('{rsp_action, rsp_sequence_res, rsp_start_timer, rsp_stop_timer,
                               rsp_window_now, rsp_threshold_now, rsp_threshold_unset,
                               rsp_in_slow_start, rsp_flight_now});
         rx_cycle++;
         if (rsp_hold_req && !rsp_hold_seen) begin
            rsp_hold_left = 500;
            rsp_hold_seen = 1'b1;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if ((rx_cycle % 5000) < 1000) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 15);
         end
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      ramp_to_limits();
      directed_cases();
      random_traffic(1050);
      finish_transfer();
      req_valid <= 1'b0;
      while (sb.expected_cmds.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #20000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tscc_pkg.sv
sv/tscc_credit.sv
sv/tscc_core.sv
sv/tcp_sender_congestion_control.sv
tb/tscc_tb_pkg.sv
tb/tb_tcp_sender_congestion_control.sv
